FILE: rtl/md5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package md5_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } md5_in_t;

  typedef struct packed {
    logic [63:0] digest_part;
    logic        part_index;
    logic        last_part;
  } md5_out_t;

  typedef enum logic [1:0] {
    ACT_ABSORB      = 2'd0,
    ACT_ABSORB_FIN  = 2'd1,
    ACT_FIN_RESTART = 2'd2,
    ACT_FIN_KEEP    = 2'd3
  } md5_action_t;

  localparam logic [2:0] CFG_A     = 3'd0;
  localparam logic [2:0] CFG_B     = 3'd1;
  localparam logic [2:0] CFG_C     = 3'd2;
  localparam logic [2:0] CFG_D     = 3'd3;
  localparam logic [2:0] CFG_COUNT = 3'd4;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_CMP_PRE,
    ST_CMP_RUN,
    ST_CMP_ADD,
    ST_FIN,
    ST_OUT0,
    ST_OUT1
  } md5_state_t;

  // per-step additive constants
  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] t [64];
    t = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
    return t[i];
  endfunction

  // rotate amount for a step
  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // message word index for a step
  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
      default: g = 4'(i[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_swap(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } md5_cmp_req_t;

  typedef struct packed {
    logic [3:0] word_idx;
    logic       done;
  } md5_cmp_sts_t;

endpackage
`default_nettype wire

FILE: rtl/md5_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module md5_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic      [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

FILE: rtl/md5_round.sv
`timescale 1ns / 1ps
`default_nettype none
module md5_round import md5_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire md5_cmp_req_t req,
  input  wire logic [31:0]  word,
  output md5_cmp_sts_t      sts,
  output logic [31:0]       a_out,
  output logic [31:0]       b_out,
  output logic [31:0]       c_out,
  output logic [31:0]       d_out
);
  logic [31:0] a_r, b_r, c_r, d_r;
  logic [5:0]  step_r;
  logic        busy_r, prime_r;
  logic [31:0] f, sum, rot;
  logic [5:0]  nstep;
  logic [4:0]  s;

  // the word for step i is requested in the cycle before step i runs
  assign nstep = (busy_r && prime_r) ? 6'(step_r + 6'd1) : 6'd0;
  assign sts.word_idx = md5_g(nstep);
  assign sts.done = busy_r && prime_r && step_r == 6'd63;

  always_comb begin
    case (step_r[5:4])
      2'd0: f = (b_r & c_r) | (~b_r & d_r);
      2'd1: f = (b_r & d_r) | (c_r & ~d_r);
      2'd2: f = b_r ^ c_r ^ d_r;
      default: f = c_r ^ (b_r | ~d_r);
    endcase
    s = md5_s(step_r);
    sum = a_r + f + word + md5_k(step_r);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  // one step per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      prime_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      prime_r <= 1'b0;
      step_r <= '0;
      a_r <= req.a; b_r <= req.b; c_r <= req.c; d_r <= req.d;
    end else if (busy_r && !prime_r) begin
      prime_r <= 1'b1;
    end else if (busy_r) begin
      a_r <= d_r; d_r <= c_r; c_r <= b_r;
      b_r <= b_r + rot;
      if (step_r == 6'd63) begin
        busy_r <= 1'b0;
        prime_r <= 1'b0;
      end else begin
        step_r <= 6'(step_r + 6'd1);
      end
    end
  end

  // working words after the last step
  assign a_out = a_r;
  assign b_out = b_r;
  assign c_out = c_r;
  assign d_out = d_r;
endmodule
`default_nettype wire

FILE: rtl/md5_message_digest.sv
`timescale 1ns / 1ps
`default_nettype none
// MD5 hash engine, one message byte per input word. An absorb word is taken in
// idle and then holds the input while its block word in a 16x32 memory is read
// and written back; no new word is taken before that write. The word that fills
// a block then runs the compression: a start state, a prime of the memory read,
// 64 steps and a final add. A finalize never writes the block memory: the 0x80
// marker, the zero fill and the bit length are put in place of the words read
// during compression, so the block contents stay intact for a finalize that
// keeps state. A finalize runs a setup state, one compression (two when 56 or
// more bytes of the block are filled) and then offers the digest as two 64-bit
// result words, each held until taken. Chaining words and the byte count sit in
// registers; restart reloads them from the start registers as the second digest
// word leaves.
module md5_message_digest import md5_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire md5_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output md5_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  md5_state_t state_r, state_nxt;
  logic [31:0] st_a_r, st_b_r, st_c_r, st_d_r;
  logic [63:0] st_cnt_r, cnt_r, cnt_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        final_r, final_nxt;     // compression belongs to finalize
  logic        second_r, second_nxt;   // length block pending
  logic        lenblk_r, lenblk_nxt;   // running the length-only block
  logic [63:0] fin_cnt_r, fin_cnt_nxt;
  logic [31:0] cv_a_r, cv_b_r, cv_c_r, cv_d_r;
  logic [31:0] wa_r, wb_r, wc_r, wd_r;
  logic [31:0] ba, bb, bc, bd;
  logic [31:0] fa, fb, fc, fd;
  logic        rst_cv_r;

  // block memory ports
  logic        bw_we;
  logic [3:0]  bw_wa, bw_ra, widx_r;
  logic [31:0] bw_wd, bw_rd, cword;
  md5_cmp_req_t creq;
  md5_cmp_sts_t csts;
  logic [31:0] ra, rb, rc, rd;

  md5_ram #(.Width(32), .Depth(16)) u_block (
    .clk, .wr_en(bw_we), .wr_addr(bw_wa), .wr_data(bw_wd),
    .rd_addr(bw_ra), .rd_data(bw_rd));

  md5_round u_round (
    .clk, .rst_n, .req(creq), .word(cword), .sts(csts),
    .a_out(ra), .b_out(rb), .c_out(rc), .d_out(rd));

  // finalize works on a copy of the chaining words
  assign ba = final_r ? wa_r : cv_a_r;
  assign bb = final_r ? wb_r : cv_b_r;
  assign bc = final_r ? wc_r : cv_c_r;
  assign bd = final_r ? wd_r : cv_d_r;
  assign fa = ba + ra;
  assign fb = bb + rb;
  assign fc = bc + rc;
  assign fd = bd + rd;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_a_r <= INIT_A; st_b_r <= INIT_B; st_c_r <= INIT_C; st_d_r <= INIT_D;
      st_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_A: st_a_r <= cfg_data[31:0];
        CFG_B: st_b_r <= cfg_data[31:0];
        CFG_C: st_c_r <= cfg_data[31:0];
        CFG_D: st_d_r <= cfg_data[31:0];
        CFG_COUNT: st_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [5:0] pos, fpos;
  logic [4:0] lane;
  logic [31:0] mask, padw;
  assign pos = cnt_r[5:0];
  assign fpos = fin_cnt_r[5:0];
  assign lane = {pos[1:0], 3'b000};
  assign mask = (32'h1 << lane) - 32'h1;
  // count is steady during finalize, so pos marks the pad point
  assign padw = (bw_rd & mask) | (32'h80 << lane);

  // word fed to the compression: padding and length replace stored words
  always_comb begin
    cword = bw_rd;
    if (final_r) begin
      if (lenblk_r || widx_r > fpos[5:2]) cword = '0;
      else if (widx_r == fpos[5:2]) cword = padw;
      if (!second_r && widx_r == 4'd14) cword = {fin_cnt_r[28:0], 3'b000};
      if (!second_r && widx_r == 4'd15) cword = fin_cnt_r[60:29];
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    act_nxt = act_r;
    byte_nxt = byte_r;
    final_nxt = final_r;
    second_nxt = second_r;
    lenblk_nxt = lenblk_r;
    fin_cnt_nxt = fin_cnt_r;
    in_stall = 1'b1;
    bw_we = 1'b0;
    bw_wa = pos[5:2];
    bw_wd = '0;
    bw_ra = pos[5:2];
    creq = '0;
    creq.a = ba; creq.b = bb; creq.c = bc; creq.d = bd;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          act_nxt = in_data.action;
          byte_nxt = in_data.data_byte;
          fin_cnt_nxt = cnt_r;
          if (in_data.action == ACT_ABSORB || in_data.action == ACT_ABSORB_FIN) begin
            state_nxt = ST_RMW_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_RMW_RD: state_nxt = ST_RMW_WR;
      ST_RMW_WR: begin
        bw_we = 1'b1;
        bw_wd = (bw_rd & ~(32'hFF << lane)) | ({24'd0, byte_r} << lane);
        cnt_nxt = 64'(cnt_r + 64'd1);
        fin_cnt_nxt = 64'(cnt_r + 64'd1);
        final_nxt = 1'b0;
        if (pos == 6'd63) begin
          state_nxt = ST_CMP_PRE;
        end else if (act_r == ACT_ABSORB_FIN) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CMP_PRE: begin
        creq.start = 1'b1;
        bw_ra = csts.word_idx;
        state_nxt = ST_CMP_RUN;
      end
      ST_CMP_RUN: begin
        bw_ra = csts.word_idx;
        if (csts.done) state_nxt = ST_CMP_ADD;
      end
      ST_CMP_ADD: begin
        if (!final_r) begin
          state_nxt = (act_r == ACT_ABSORB_FIN) ? ST_FIN : ST_IDLE;
        end else if (second_r) begin
          // length-only block follows
          second_nxt = 1'b0;
          lenblk_nxt = 1'b1;
          state_nxt = ST_CMP_PRE;
        end else begin
          state_nxt = ST_OUT0;
        end
      end
      ST_FIN: begin
        final_nxt = 1'b1;
        second_nxt = (fpos >= 6'd56);
        lenblk_nxt = 1'b0;
        state_nxt = ST_CMP_PRE;
      end
      ST_OUT0, ST_OUT1: begin
        if (!out_stall) begin
          if (state_r == ST_OUT0) state_nxt = ST_OUT1;
          else state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      final_r <= 1'b0;
      second_r <= 1'b0;
      lenblk_r <= 1'b0;
      rst_cv_r <= 1'b1;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      second_r <= second_nxt;
      lenblk_r <= lenblk_nxt;
      cnt_r <= cnt_nxt;
      rst_cv_r <= 1'b0;
      if (state_r == ST_OUT1 && !out_stall && act_r != ACT_FIN_KEEP) begin
        cnt_r <= st_cnt_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    byte_r <= byte_nxt;
    fin_cnt_r <= fin_cnt_nxt;
    widx_r <= bw_ra;
    if (rst_cv_r || (state_r == ST_OUT1 && !out_stall && act_r != ACT_FIN_KEEP)) begin
      cv_a_r <= st_a_r; cv_b_r <= st_b_r; cv_c_r <= st_c_r; cv_d_r <= st_d_r;
    end else if (state_r == ST_CMP_ADD) begin
      if (final_r) begin
        wa_r <= fa; wb_r <= fb; wc_r <= fc; wd_r <= fd;
      end else begin
        cv_a_r <= fa; cv_b_r <= fb; cv_c_r <= fc; cv_d_r <= fd;
      end
    end else if (state_r == ST_FIN) begin
      wa_r <= cv_a_r; wb_r <= cv_b_r; wc_r <= cv_c_r; wd_r <= cv_d_r;
    end
  end

  assign out_valid = (state_r == ST_OUT0) || (state_r == ST_OUT1);
  assign out_data.digest_part = (state_r == ST_OUT1) ?
      {md5_swap(wc_r), md5_swap(wd_r)} : {md5_swap(wa_r), md5_swap(wb_r)};
  assign out_data.part_index = (state_r == ST_OUT1);
  assign out_data.last_part = (state_r == ST_OUT1);

  // digest words only follow a finalize compression, the second after the first
  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT1) |-> ($past(state_r) == ST_OUT0 || $past(state_r) == ST_OUT1))
    else $error("second digest word without first");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_cmp_done: assert property (@(posedge clk) disable iff (!rst_n)
    csts.done |-> state_r == ST_CMP_RUN)
    else $error("compression finished outside run state");
endmodule
`default_nettype wire

FILE: dv/md5_message_digest_test.sv
`timescale 1ns / 1ps
module md5_message_digest_test;
  import md5_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  md5_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  md5_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = CFG_A;
  logic [63:0] cfg_data = '0;

  md5_message_digest u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // digest predictor state
  logic [31:0] step_add [64];
  logic [31:0] start_a, start_b, start_c, start_d;
  logic [63:0] start_count;
  logic [31:0] chain [4];
  logic [31:0] msg_block [16];
  logic [63:0] msg_count;
  md5_out_t    digest_words [$];

  int errors = 0;
  int cycles = 0;
  bit quiet = 1'b0;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_burst = 0;

  function automatic logic [31:0] byte_rev(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // 64-step compression folded into the chaining words
  function automatic void md5_block(ref logic [31:0] cv[4], input logic [31:0] w[16]);
    int rot [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    logic [31:0] a, b, c, d, f, t;
    int g, s;
    a = cv[0]; b = cv[1]; c = cv[2]; d = cv[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      s = rot[(i / 16) * 4 + i % 4];
      t = a + f + w[g] + step_add[i];
      a = d; d = c; c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    cv[0] += a; cv[1] += b; cv[2] += c; cv[3] += d;
  endfunction

  function automatic void restart_chain();
    chain[0] = start_a; chain[1] = start_b; chain[2] = start_c; chain[3] = start_d;
    msg_count = start_count;
  endfunction

  function automatic void absorb_byte(input logic [7:0] data);
    logic [5:0] pos;
    pos = msg_count[5:0];
    msg_block[pos[5:2]][pos[1:0] * 8 +: 8] = data;
    msg_count++;
    if (pos == 6'd63) md5_block(chain, msg_block);
  endfunction

  // pad a copy of the state and queue both digest words
  function automatic void finish_digest();
    logic [31:0] cv [4];
    logic [31:0] w [16];
    logic [5:0]  pos;
    logic [63:0] bits;
    md5_out_t    r;
    cv = chain;
    w = msg_block;
    pos = msg_count[5:0];
    bits = msg_count << 3;
    for (int k = 0; k < 4; k++)
      if (k > pos[1:0]) w[pos[5:2]][k * 8 +: 8] = 8'h00;
    w[pos[5:2]][pos[1:0] * 8 +: 8] = 8'h80;
    for (int k = pos[5:2] + 1; k < 16; k++) w[k] = '0;
    if (pos >= 6'd56) begin
      md5_block(cv, w);
      foreach (w[k]) w[k] = '0;
    end
    w[14] = bits[31:0];
    w[15] = bits[63:32];
    md5_block(cv, w);
    r.digest_part = {byte_rev(cv[0]), byte_rev(cv[1])};
    r.part_index = 1'b0;
    r.last_part = 1'b0;
    digest_words.push_back(r);
    r.digest_part = {byte_rev(cv[2]), byte_rev(cv[3])};
    r.part_index = 1'b1;
    r.last_part = 1'b1;
    digest_words.push_back(r);
  endfunction

  function automatic void predict_word(input md5_in_t w);
    case (md5_action_t'(w.action))
      ACT_ABSORB: absorb_byte(w.data_byte);
      ACT_ABSORB_FIN: begin
        absorb_byte(w.data_byte);
        finish_digest();
        restart_chain();
      end
      ACT_FIN_RESTART: begin
        finish_digest();
        restart_chain();
      end
      default: finish_digest();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // cycle count and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("md5_message_digest_test NOT OK");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    md5_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_words.size() == 0) begin
        report_mismatch("unexpected word", out_data.digest_part, '0);
      end else begin
        want = digest_words.pop_front();
        if (out_data.digest_part !== want.digest_part)
          report_mismatch("digest_part", out_data.digest_part, want.digest_part);
        if (out_data.part_index !== want.part_index)
          report_mismatch("part_index", 64'(out_data.part_index), 64'(want.part_index));
        if (out_data.last_part !== want.last_part)
          report_mismatch("last_part", 64'(out_data.last_part), 64'(want.last_part));
      end
    end
  end

  // receiver stalls: random bursts, long hold-offs on request, none when quiet
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_burst > 0) begin
      stall_burst <= stall_burst - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_burst <= $urandom_range(0, 8);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // send one word, with an optional idle burst first
  task automatic send_word(input md5_action_t act, input logic [7:0] data);
    md5_in_t w;
    w.action = act;
    w.data_byte = data;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_word(w);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    go_idle();
    while (digest_words.size() != 0) @(posedge clk);
  endtask

  task automatic send_message(input int len, input md5_action_t fin);
    for (int i = 0; i < len; i++) send_word(ACT_ABSORB, 8'($urandom));
    send_word(fin, 8'($urandom));
  endtask

  // register writes only once the engine is idle
  task automatic write_start(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d,
                             input logic [63:0] count);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_A; cfg_data <= 64'(a); @(posedge clk);
    cfg_index <= CFG_B; cfg_data <= 64'(b); @(posedge clk);
    cfg_index <= CFG_C; cfg_data <= 64'(c); @(posedge clk);
    cfg_index <= CFG_D; cfg_data <= 64'(d); @(posedge clk);
    cfg_index <= CFG_COUNT; cfg_data <= count; @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    start_a = a; start_b = b; start_c = c; start_d = d;
    start_count = count;
  endtask

  task automatic random_messages(input int n_msgs);
    md5_action_t fin;
    int len;
    for (int m = 0; m < n_msgs; m++) begin
      fin = md5_action_t'($urandom_range(1, 3));
      if ($urandom_range(0, 9) == 0) begin
        // noise word of any kind
        send_word(md5_action_t'($urandom_range(0, 3)), 8'($urandom));
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 130) : $urandom_range(0, 20);
        send_message(len, fin);
      end
    end
  endtask

  // empty message, single bytes, byte extremes, finalize keeping state
  task automatic test_directed();
    send_word(ACT_FIN_RESTART, 8'h00);
    send_word(ACT_ABSORB_FIN, 8'h61);
    send_word(ACT_ABSORB, 8'h61);
    send_word(ACT_ABSORB, 8'h62);
    send_word(ACT_ABSORB_FIN, 8'h63);
    send_word(ACT_ABSORB, 8'hFF);
    send_word(ACT_ABSORB, 8'h00);
    send_word(ACT_FIN_KEEP, 8'hA5);
    send_word(ACT_ABSORB, 8'h5A);
    send_word(ACT_FIN_KEEP, 8'h00);
    send_word(ACT_ABSORB_FIN, 8'hFF);
    send_word(ACT_FIN_RESTART, 8'hFF);
  endtask

  // block boundaries: one- and two-block padding
  task automatic test_block_fill();
    send_message(55, ACT_FIN_RESTART);
    send_message(56, ACT_FIN_RESTART);
    send_message(63, ACT_ABSORB_FIN);
    send_message(64, ACT_FIN_KEEP);
    send_word(ACT_FIN_RESTART, 8'h00);
  endtask

  // start state extremes, count wrap, unaligned start count
  task automatic test_start_state();
    write_start('0, '0, '0, '0, '0);
    send_word(ACT_FIN_RESTART, 8'h00);
    send_message(3, ACT_FIN_RESTART);
    write_start('1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFC0);
    send_word(ACT_FIN_RESTART, 8'h00);
    send_message(80, ACT_FIN_KEEP);
    send_word(ACT_FIN_RESTART, 8'h00);
    write_start(32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210, '1);
    send_word(ACT_FIN_RESTART, 8'h00);
    send_message(2, ACT_FIN_RESTART);
    write_start($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
    send_word(ACT_FIN_RESTART, 8'h00);
    random_messages(3);
    write_start(INIT_A, INIT_B, INIT_C, INIT_D, '0);
    send_word(ACT_FIN_RESTART, 8'h00);
  endtask

  // receiver holds off while short messages keep coming, then sender waits
  task automatic test_backpressure();
    hold_ask++;
    for (int m = 0; m < 6; m++) send_message($urandom_range(0, 4), ACT_FIN_KEEP);
    send_word(ACT_FIN_RESTART, 8'h00);
    wait_drained();
    random_messages(3);
    wait_drained();
  endtask

  initial begin
    int x;
    for (int i = 0; i < 64; i++) begin
      x = i;
      step_add[i] = 32'(longint'($floor($sin(real'(x + 1)) < 0.0 ?
                     -$sin(real'(x + 1)) * 4294967296.0 :
                     $sin(real'(x + 1)) * 4294967296.0)));
    end
    start_a = INIT_A; start_b = INIT_B; start_c = INIT_C; start_d = INIT_D;
    start_count = '0;
    foreach (msg_block[k]) msg_block[k] = '0;
    restart_chain();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_block_fill();
    random_messages(5);
    test_start_state();
    test_backpressure();
    random_messages(2);
    quiet = 1'b1;
    random_messages(3);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_words.size() != 0) begin
      report_mismatch("digest words never arrived", 64'(digest_words.size()), '0);
    end
    if (errors == 0) begin
      $display("md5_message_digest_test OK");
    end else begin
      $display("md5_message_digest_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/md5_pkg.sv
rtl/md5_ram.sv
rtl/md5_round.sv
rtl/md5_message_digest.sv
dv/md5_message_digest_test.sv
